// ===== rtl/fps_pkg.sv =====
package fps_pkg;

   // flow table depth and the widths derived from it
   localparam int MAX_FLOWS  = 256;
   localparam int FLOW_IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int FLOW_CNT_W = $clog2(MAX_FLOWS + 1);

   // protocols that carry ports
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // configuration registers
   localparam int          CSR_ADDR_W       = 4;
   localparam logic [1:0]  REG_TIMER_MODE   = 2'd0;
   localparam logic [1:0]  REG_START_SECOND = 2'd1;
   localparam logic [1:0]  REG_INTERVAL     = 2'd2;
   localparam logic [15:0] DEFAULT_INTERVAL = 16'd60;

   // five-tuple key as kept in the flow table
   typedef struct packed {
      logic [63:0] addr_pair;
      logic [39:0] port_proto;
   } fps_key_type;

   // what travels from cell to cell beside its valid bit
   typedef struct packed {
      logic        found;
      logic        inserted;
      fps_key_type key;
   } fps_token_type;

endpackage

// ===== rtl/fps_channels.sv =====
interface fps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [7:0]  proto_num;
   logic [15:0] ip_length;
   logic [31:0] timestamp_sec;

   modport source (
      output valid, src_ip, dst_ip, src_port, dst_port, proto_num, ip_length, timestamp_sec,
      input  ready
   );
   modport sink (
      input  valid, src_ip, dst_ip, src_port, dst_port, proto_num, ip_length, timestamp_sec,
      output ready
   );
endinterface

interface fps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] report_number;
   logic [31:0] packet_total;
   logic [47:0] byte_total;
   logic [8:0]  flow_total;

   modport source (
      output valid, report_number, packet_total, byte_total, flow_total,
      input  ready
   );
   modport sink (
      input  valid, report_number, packet_total, byte_total, flow_total,
      output ready
   );
endinterface

// ===== rtl/flow_period_statistics_core.sv =====
// channel   dir  handshake          carries
// req_chan  in   valid/ready        packet descriptor, one five-tuple per item
// rsp_chan  out  valid/ready        period report, at most one per item
// apb       in   psel/penable/...   timer_mode, start_second, interval_seconds
//
// one item occupies the block from accept until busy clears: key
// register, each cell of the flow table chain in turn, then the clear of busy
// the period check, report and packet/byte counts are settled at the accept edge
// synchronous active-high reset; the flow table itself is not cleared, the
// flow count bounds which cells take part in a match
// a waiting report does not hold off the next item once it is taken or absent
module flow_period_statistics_core (
   input  logic                             clock,
   input  logic                             reset,
   fps_req_if.sink                          req_chan,
   fps_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fps_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import fps_pkg::*;

   // configuration registers
   logic        timer_mode_ff;
   logic [31:0] start_second_ff;
   logic [15:0] interval_ff;

   // period state
   logic [31:0] period_base_ff, period_base_in;
   logic [31:0] report_seq_ff,  report_seq_in;
   logic [31:0] packets_ff,     packets_in;
   logic [47:0] bytes_ff,       bytes_in;
   logic [FLOW_CNT_W-1:0] flows_used_ff, flows_used_in;

   // control
   logic busy_ff, busy_in;
   logic rsp_valid_ff, rsp_valid_in;

   // report register
   logic [31:0] rsp_number_ff;
   logic [31:0] rsp_packets_ff;
   logic [47:0] rsp_bytes_ff;
   logic [FLOW_CNT_W-1:0] rsp_flows_ff;

   // key injection into the chain
   logic          inject_valid_ff;
   fps_token_type inject_tok_ff, inject_tok_in;

   logic          chain_valid;
   fps_token_type chain_tok;

   logic        accept;
   logic        csr_write;
   logic        boundary;
   logic        has_ports;
   logic [31:0] elapsed;
   logic [31:0] packets_base;
   logic [47:0] bytes_base;
   logic [48:0] bytes_sum;
   logic [15:0] sport, dport;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // one item in the chain at a time; a pending report must be leaving
   assign req_chan.ready = !busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // period boundary, checked before the packet is counted
   assign elapsed = req_chan.timestamp_sec - period_base_ff;
   always_comb begin
      if (timer_mode_ff) begin
         boundary = (req_chan.timestamp_sec >= period_base_ff) &&
                    (elapsed >= {16'd0, interval_ff});
      end else begin
         boundary = req_chan.timestamp_sec > period_base_ff;
      end
   end

   // counters restart from zero when a period closes
   assign packets_base = boundary ? 32'd0 : packets_ff;
   assign bytes_base   = boundary ? 48'd0 : bytes_ff;
   assign bytes_sum    = {1'b0, bytes_base} + {33'd0, req_chan.ip_length};

   // ports only count for tcp and udp
   assign has_ports = (req_chan.proto_num == PROTO_TCP) || (req_chan.proto_num == PROTO_UDP);
   assign sport     = has_ports ? req_chan.src_port : 16'd0;
   assign dport     = has_ports ? req_chan.dst_port : 16'd0;

   always_comb begin
      inject_tok_in                     = '0;
      inject_tok_in.key.addr_pair       = {req_chan.src_ip, req_chan.dst_ip};
      inject_tok_in.key.port_proto      = {sport, dport, req_chan.proto_num};
   end

   always_comb begin
      period_base_in = period_base_ff;
      report_seq_in  = report_seq_ff;
      packets_in     = packets_ff;
      bytes_in       = bytes_ff;
      flows_used_in  = flows_used_ff;
      busy_in        = busy_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // the item leaves the chain: busy clears, and a new flow that found its cell is counted
      if (chain_valid) begin
         busy_in = 1'b0;
         if (chain_tok.inserted) begin
            flows_used_in = flows_used_ff + FLOW_CNT_W'(1);
         end
      end

      if (accept) begin
         busy_in      = 1'b1;
         rsp_valid_in = boundary;
         if (boundary) begin
            flows_used_in = '0;
            if (report_seq_ff != 32'hFFFF_FFFF) begin
               report_seq_in = report_seq_ff + 32'd1;
            end
            period_base_in = timer_mode_ff ? req_chan.timestamp_sec : period_base_ff + 32'd1;
         end
         packets_in = (packets_base == 32'hFFFF_FFFF) ? packets_base : packets_base + 32'd1;
         bytes_in   = bytes_sum[48] ? 48'hFFFF_FFFF_FFFF : bytes_sum[47:0];
      end

      // a start second write also reloads the base
      if (csr_write && (paddr[3:2] == REG_START_SECOND)) begin
         period_base_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff   <= 1'b0;
         start_second_ff <= 32'd0;
         interval_ff     <= DEFAULT_INTERVAL;
         period_base_ff  <= 32'd0;
         report_seq_ff   <= 32'd1;
         packets_ff      <= 32'd0;
         bytes_ff        <= 48'd0;
         flows_used_ff   <= '0;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         inject_valid_ff <= 1'b0;
      end else begin
         period_base_ff  <= period_base_in;
         report_seq_ff   <= report_seq_in;
         packets_ff      <= packets_in;
         bytes_ff        <= bytes_in;
         flows_used_ff   <= flows_used_in;
         busy_ff         <= busy_in;
         rsp_valid_ff    <= rsp_valid_in;
         inject_valid_ff <= accept;
         if (csr_write) begin
            case (paddr[3:2])
               REG_TIMER_MODE:   timer_mode_ff   <= pwdata[0];
               REG_START_SECOND: start_second_ff <= pwdata;
               REG_INTERVAL:     interval_ff     <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // report and key payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         inject_tok_ff <= inject_tok_in;
      end
      if (accept && boundary) begin
         rsp_number_ff  <= report_seq_ff;
         rsp_packets_ff <= packets_ff;
         rsp_bytes_ff   <= bytes_ff;
         rsp_flows_ff   <= flows_used_ff;
      end
   end

   // flow table: key walks the row of cells, matched or stored on the way
   fps_flow_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .flows_used (flows_used_ff),
      .in_valid   (inject_valid_ff),
      .in_tok     (inject_tok_ff),
      .out_valid  (chain_valid),
      .out_tok    (chain_tok)
   );

   always_comb begin
      case (paddr[3:2])
         REG_TIMER_MODE:   prdata = {31'd0, timer_mode_ff};
         REG_START_SECOND: prdata = start_second_ff;
         REG_INTERVAL:     prdata = {16'd0, interval_ff};
         default:          prdata = 32'd0;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.report_number = rsp_number_ff;
   assign rsp_chan.packet_total  = rsp_packets_ff;
   assign rsp_chan.byte_total    = rsp_bytes_ff;
   assign rsp_chan.flow_total    = 9'(rsp_flows_ff);

   // the chain only ever carries the item the block is busy with
   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      chain_valid |-> busy_ff)
      else $error("flow chain output without an item in flight");

   // flow count never passes the table depth
   a_flows_bound: assert property (@(posedge clock) disable iff (reset)
      flows_used_ff <= FLOW_CNT_W'(MAX_FLOWS))
      else $error("flow count beyond table depth");

   // an insert only happens with room left
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (chain_valid && chain_tok.inserted) |-> (flows_used_ff < FLOW_CNT_W'(MAX_FLOWS)))
      else $error("flow inserted into a full table");

   // a boundary yields a report carrying the sequence number of the closed period
   a_report_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && boundary) |=> (rsp_valid_ff && (rsp_number_ff == $past(report_seq_ff))))
      else $error("report missing or misnumbered after a boundary");
endmodule

// ===== rtl/fps_cell.sv =====
module fps_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fps_pkg::FLOW_IDX_W-1:0]  cell_idx,
   input  logic [fps_pkg::FLOW_CNT_W-1:0]  flows_used,
   input  logic                            in_valid,
   input  fps_pkg::fps_token_type          in_tok,
   output logic                            out_valid,
   output fps_pkg::fps_token_type          out_tok
);
   import fps_pkg::*;

   fps_key_type   entry_ff;
   logic          out_valid_ff;
   fps_token_type out_tok_ff;
   fps_token_type out_tok_in;
   logic [FLOW_CNT_W-1:0] idx_ext;
   logic          hit;
   logic          ins;

   assign idx_ext = FLOW_CNT_W'(cell_idx);

   // only entries written this period take part in the match
   assign hit = in_valid && (idx_ext < flows_used) && (entry_ff == in_tok.key);
   // first free entry takes the key when nothing earlier matched
   assign ins = in_valid && !in_tok.found && (idx_ext == flows_used);

   always_comb begin
      out_tok_in          = in_tok;
      out_tok_in.found    = in_tok.found | hit;
      out_tok_in.inserted = in_tok.inserted | ins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff <= out_tok_in;
      if (ins) begin
         entry_ff <= in_tok.key;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;
endmodule

// ===== rtl/fps_flow_chain.sv =====
module fps_flow_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fps_pkg::FLOW_CNT_W-1:0]  flows_used,
   input  logic                            in_valid,
   input  fps_pkg::fps_token_type          in_tok,
   output logic                            out_valid,
   output fps_pkg::fps_token_type          out_tok
);
   import fps_pkg::*;

   logic          link_valid [MAX_FLOWS+1];
   fps_token_type link_tok   [MAX_FLOWS+1];

   assign link_valid[0] = in_valid;
   assign link_tok[0]   = in_tok;

   for (genvar i = 0; i < MAX_FLOWS; i++) begin : g_cell
      fps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (FLOW_IDX_W'(i)),
         .flows_used (flows_used),
         .in_valid   (link_valid[i]),
         .in_tok     (link_tok[i]),
         .out_valid  (link_valid[i+1]),
         .out_tok    (link_tok[i+1])
      );
   end

   assign out_valid = link_valid[MAX_FLOWS];
   assign out_tok   = link_tok[MAX_FLOWS];
endmodule
